// File: rtl/core/amr_pkg.sv
`default_nettype none

package amr_pkg;

    // Map geometry
    localparam int MAX_COLUMNS = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);

    // Field and datapath widths
    localparam int CNT_W   = 16;
    localparam int QUO_W   = 16;
    localparam int ACC_W   = 17;
    localparam int PROD_W  = 2 * ACC_W;
    localparam int SUM_W   = 52;
    localparam int CFG_W   = 9;
    localparam int STEP_W  = 4;

    // APB port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_IDX_COLS = '0;
    localparam logic [CFG_W-1:0]     COLS_RESET   = 9'd256;

    // Acceptance codes in Q1.16
    localparam logic [ACC_W-1:0] ACC_ONE = 17'h10000;
    localparam logic [ACC_W-1:0] ACC_MIN = 17'h00001;

    // Sequencer step limits
    localparam logic [STEP_W-1:0] DIV_LAST  = 4'd15;
    localparam logic [STEP_W-1:0] TERM_LAST = 4'd4;
    localparam logic [STEP_W-1:0] RD_UP     = 4'd0;
    localparam logic [STEP_W-1:0] CAP_UP    = 4'd1;
    localparam logic [STEP_W-1:0] CAP_RIGHT = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_TERM,
        ST_FIN
    } amr_state_t;

    // Neighbor visited at each term step
    typedef enum logic [1:0] {
        NB_LEFT,
        NB_UPLEFT,
        NB_UP,
        NB_UPRIGHT
    } amr_nb_t;

    typedef struct packed {
        logic load;
        logic step;
    } amr_div_ctrl_t;

    typedef struct packed {
        logic mul_en;
        logic pair_en;
        logic clear;
    } amr_acc_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/amr_ram.sv
`default_nettype none

module amr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/amr_div.sv
`default_nettype none

module amr_div (
    input  wire logic                            clk,
    input  wire amr_pkg::amr_div_ctrl_t          ctrl,
    input  wire logic [amr_pkg::CNT_W-1:0]       dividend,
    input  wire logic [amr_pkg::CNT_W-1:0]       divisor,
    output logic      [amr_pkg::QUO_W-1:0]       quotient
);

    import amr_pkg::*;

    logic [CNT_W-1:0] rem_reg;
    logic [CNT_W-1:0] rem_next;
    logic [CNT_W-1:0] dsr_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [CNT_W:0]   trial;
    logic             fits;

    // One restoring step: shift in a zero, subtract if it fits
    always_comb
    begin
        trial    = {rem_reg, 1'b0};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? CNT_W'(trial - {1'b0, dsr_reg}) : trial[CNT_W-1:0];
        quo_next = {quo_reg[QUO_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/amr_acc.sv
`default_nettype none

module amr_acc (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire amr_pkg::amr_acc_ctrl_t      ctrl,
    input  wire logic [amr_pkg::ACC_W-1:0]   val_a,
    input  wire logic [amr_pkg::ACC_W-1:0]   val_b,
    output logic      [amr_pkg::SUM_W-1:0]   sum,
    output logic                             clip
);

    import amr_pkg::*;

    logic [ACC_W-1:0]  diff;
    logic [PROD_W-1:0] sq;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              prod_vld_reg;
    logic              prod_vld_next;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              clip_reg;
    logic              clip_next;

    // Form twice the squared difference of a counted pair
    always_comb
    begin
        diff          = (val_a > val_b) ? (val_a - val_b) : (val_b - val_a);
        sq            = PROD_W'(diff) * PROD_W'(diff);
        prod_next     = {sq[PROD_W-2:0], 1'b0};
        prod_vld_next = ctrl.mul_en && ctrl.pair_en && (val_a != '0) && (val_b != '0);
    end

    // Add the registered term, clip at full scale
    always_comb
    begin
        sum_ext   = {1'b0, sum_reg} + (SUM_W + 1)'(prod_reg);
        sum_next  = sum_reg;
        clip_next = clip_reg;
        if (ctrl.clear)
        begin
            sum_next  = '0;
            clip_next = 1'b0;
        end
        else if (prod_vld_reg)
        begin
            if (sum_ext[SUM_W])
            begin
                sum_next  = '1;
                clip_next = 1'b1;
            end
            else
            begin
                sum_next = sum_ext[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            sum_reg      <= '0;
            clip_reg     <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= prod_vld_next && !ctrl.clear;
            sum_reg      <= sum_next;
            clip_reg     <= clip_next;
        end
    end

    assign sum  = sum_reg;
    assign clip = clip_reg;

endmodule

`default_nettype wire

// File: rtl/core/acceptance_map_roughness.sv
// A result enters the output register in the FIN state of the bin flagged last.
// One bin at a time: in_ready is low from a bin's transfer through the divider's 16
//   quotient steps, the multiply-accumulate steps on four neighbors and the write.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the running sum,
//   the row position and all row-store valid bits, and sets the column count to 256.
//   No clearing pass runs: the block takes bins in the first cycle after reset.
`default_nettype none

module acceptance_map_roughness (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // APB configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [amr_pkg::PADDR_W-1:0]       paddr,
    input  wire logic [amr_pkg::PDATA_W-1:0]       pwdata,
    output logic      [amr_pkg::PDATA_W-1:0]       prdata,
    output logic                                   pready,
    // Bin input
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [amr_pkg::CNT_W-1:0]         accepted_count,
    input  wire logic [amr_pkg::CNT_W-1:0]         raw_count,
    input  wire logic                              last_bin,
    // Result output
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic      [amr_pkg::SUM_W-1:0]         roughness,
    output logic                                   saturated
);

    import amr_pkg::*;

    amr_state_t        state_reg;
    amr_state_t        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    logic [CFG_W-1:0]  cols_cfg_reg;
    logic [COLS_W-1:0] cols_eff;
    logic              cfg_wr;

    logic [COL_W-1:0]  pos_reg;
    logic              first_reg;
    logic [COL_W-1:0]  c_reg;
    logic              cfirst_reg;
    logic              last_reg;
    logic              acc_zero_reg;
    logic              raw_zero_reg;
    logic              ge_reg;
    logic              pos_wrap;
    logic [COLS_W-1:0] c_plus1;
    logic              has_right;

    logic [ACC_W-1:0]  left_reg;
    logic [ACC_W-1:0]  upleft_reg;
    logic [ACC_W-1:0]  above_reg;
    logic [ACC_W-1:0]  upright_reg;
    logic [ACC_W-1:0]  v_cur;
    logic [ACC_W-1:0]  nb_val;
    logic              nb_en;
    amr_nb_t           nb_sel;

    logic [MAX_COLUMNS-1:0] vbit_reg;
    logic                   rvld_reg;
    logic [COL_W-1:0]       raddr;
    logic [ACC_W-1:0]       rdata;
    logic [ACC_W-1:0]       rd_val;
    logic                   ram_we;

    logic [QUO_W-1:0]  quotient;
    amr_div_ctrl_t     div_ctrl;
    amr_acc_ctrl_t     acc_ctrl;
    logic [SUM_W-1:0]  sum;
    logic              clip;

    logic              in_xfer;
    logic              out_free;
    logic              out_load;
    logic              out_valid_reg;
    logic [SUM_W-1:0]  roughness_reg;
    logic              saturated_reg;

    // Configuration register
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[PADDR_W-1:2] == REG_IDX_COLS)
        begin
            prdata = PDATA_W'(cols_cfg_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= COLS_RESET;
        end
        else if (cfg_wr && (paddr[PADDR_W-1:2] == REG_IDX_COLS))
        begin
            cols_cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Clamp the column count into one to the row-store depth
    always_comb
    begin
        priority if (cols_cfg_reg == '0)
        begin
            cols_eff = COLS_W'(1);
        end
        else if (32'(cols_cfg_reg) > 32'(MAX_COLUMNS))
        begin
            cols_eff = COLS_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = COLS_W'(cols_cfg_reg);
        end
    end

    // Row position of the incoming bin and of its right neighbor
    assign pos_wrap  = COLS_W'(pos_reg) >= cols_eff;
    assign c_plus1   = COLS_W'(c_reg) + COLS_W'(1);
    assign has_right = c_plus1 < cols_eff;

    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_TERM;
                end
            end
            ST_TERM:
            begin
                if (step_reg == TERM_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        step_next = (state_next != state_reg) ? '0 : step_reg + STEP_W'(1);
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready         = 1'b0;
        div_ctrl.load    = 1'b0;
        div_ctrl.step    = 1'b0;
        acc_ctrl.mul_en  = 1'b0;
        acc_ctrl.pair_en = nb_en;
        acc_ctrl.clear   = 1'b0;
        ram_we           = 1'b0;
        out_load         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                div_ctrl.load = in_valid;
            end
            ST_DIV:
            begin
                div_ctrl.step = 1'b1;
            end
            ST_TERM:
            begin
                acc_ctrl.mul_en = step_reg != TERM_LAST;
                ram_we          = step_reg == TERM_LAST;
            end
            ST_FIN:
            begin
                out_load       = last_reg && out_free;
                acc_ctrl.clear = last_reg && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Capture the bin and its place in the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg        <= '0;
            cfirst_reg   <= 1'b1;
            last_reg     <= 1'b0;
            acc_zero_reg <= 1'b0;
            raw_zero_reg <= 1'b0;
            ge_reg       <= 1'b0;
        end
        else if (in_xfer)
        begin
            c_reg        <= pos_wrap ? '0 : pos_reg;
            cfirst_reg   <= pos_wrap ? 1'b0 : first_reg;
            last_reg     <= last_bin;
            acc_zero_reg <= accepted_count == '0;
            raw_zero_reg <= raw_count == '0;
            ge_reg       <= accepted_count >= raw_count;
        end
    end

    amr_div u_div (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (accepted_count),
        .divisor  (raw_count),
        .quotient (quotient)
    );

    // Acceptance of the current bin
    always_comb
    begin
        priority if (raw_zero_reg)
        begin
            v_cur = '0;
        end
        else if (acc_zero_reg)
        begin
            v_cur = ACC_MIN;
        end
        else if (ge_reg)
        begin
            v_cur = ACC_ONE;
        end
        else
        begin
            v_cur = {1'b0, quotient};
        end
    end

    // Row store: read the bin above, then the one to its right
    assign raddr  = (step_reg == RD_UP) ? c_reg : c_plus1[COL_W-1:0];
    assign rd_val = rvld_reg ? rdata : '0;

    amr_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_COLUMNS)
    ) u_row (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (v_cur),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbit_reg <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            rvld_reg <= vbit_reg[raddr];
            if (ram_we)
            begin
                vbit_reg[c_reg] <= 1'b1;
            end
        end
    end

    // Select the neighbor of this term step
    assign nb_sel = amr_nb_t'(step_reg[1:0]);

    always_comb
    begin
        unique case (nb_sel)
            NB_LEFT:
            begin
                nb_val = left_reg;
                nb_en  = c_reg != '0;
            end
            NB_UPLEFT:
            begin
                nb_val = upleft_reg;
                nb_en  = !cfirst_reg && (c_reg != '0);
            end
            NB_UP:
            begin
                nb_val = above_reg;
                nb_en  = !cfirst_reg;
            end
            NB_UPRIGHT:
            begin
                nb_val = upright_reg;
                nb_en  = !cfirst_reg && has_right;
            end
            default:
            begin
                nb_val = '0;
                nb_en  = 1'b0;
            end
        endcase
    end

    amr_acc u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (acc_ctrl),
        .val_a (v_cur),
        .val_b (nb_val),
        .sum   (sum),
        .clip  (clip)
    );

    // Neighbor values and row position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg   <= '0;
            upright_reg <= '0;
            left_reg    <= '0;
            upleft_reg  <= '0;
            pos_reg     <= '0;
            first_reg   <= 1'b1;
        end
        else
        begin
            if ((state_reg == ST_DIV) && (step_reg == CAP_UP))
            begin
                above_reg <= rd_val;
            end
            if ((state_reg == ST_DIV) && (step_reg == CAP_RIGHT))
            begin
                upright_reg <= rd_val;
            end
            if (ram_we)
            begin
                left_reg   <= v_cur;
                upleft_reg <= above_reg;
                priority if (last_reg)
                begin
                    pos_reg   <= '0;
                    first_reg <= 1'b1;
                end
                else if (!has_right)
                begin
                    pos_reg   <= '0;
                    first_reg <= 1'b0;
                end
                else
                begin
                    pos_reg   <= c_plus1[COL_W-1:0];
                    first_reg <= cfirst_reg;
                end
            end
        end
    end

    // Output register: hold the total until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            roughness_reg <= sum;
            saturated_reg <= clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign roughness = roughness_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

// File: rtl/core/amr_checker.sv
`default_nettype none

module amr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [amr_pkg::SUM_W-1:0]     roughness,
    input wire logic                          saturated
);

    import amr_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roughness) && $stable(saturated))
        else $error("result changed while stalled");

    // A clipped total reads as full scale
    a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> roughness == '1)
        else $error("saturated result below full scale");

    // One bin at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a bin is in work");

    // A result is posted only while the input side is closed
    a_post: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result posted while input open");

endmodule

bind acceptance_map_roughness amr_checker u_amr_checker (.*);

`default_nettype wire

// File: tb/sv/roughness_checker.sv
module roughness_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [amr_pkg::PADDR_W-1:0]   paddr,
    input  logic [amr_pkg::PDATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [amr_pkg::CNT_W-1:0]     accepted_count,
    input  logic [amr_pkg::CNT_W-1:0]     raw_count,
    input  logic                          last_bin,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [amr_pkg::SUM_W-1:0]     roughness,
    input  logic                          saturated,
    output int                            pending_totals,
    output int                            totals_checked,
    output int                            mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    import amr_pkg::*;

    localparam logic [SUM_W-1:0] SUM_LIMIT = '1;

    typedef struct packed {
        logic [SUM_W-1:0] total;
        logic             clipped;
    } map_total_t;

    // Mirror of the block state
    logic [CFG_W-1:0] columns_word;
    logic [ACC_W-1:0] row_above [MAX_COLUMNS];
    logic [ACC_W-1:0] left_ratio;
    logic [ACC_W-1:0] upleft_ratio;
    logic [COL_W-1:0] col_pos;
    logic             top_row;
    logic [SUM_W-1:0] map_sum;
    logic             map_clipped;

    map_total_t expected_totals [$];
    map_total_t oldest_total;
    int         error_count = 0;
    int         checked_count = 0;

    // Fold one neighbor pair into the map sum; skip it when either side is zero
    function automatic void add_pair_term(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
        logic [SUM_W-1:0] diff;
        logic [SUM_W-1:0] term;
        if (a == '0 || b == '0)
        begin
            return;
        end
        diff = (a > b) ? SUM_W'(a - b) : SUM_W'(b - a);
        term = (diff * diff) << 1;
        if (map_sum > SUM_LIMIT - term)
        begin
            map_sum = SUM_LIMIT;
            map_clipped = 1'b1;
        end
        else
        begin
            map_sum = map_sum + term;
        end
    endfunction

    // Advance the mirror by one bin and queue the map total on the closing bin
    function automatic void predict_bin(input logic [CNT_W-1:0] acc,
                                        input logic [CNT_W-1:0] raw,
                                        input logic             closes_map);
        logic [2*CNT_W-1:0] quotient;
        logic [ACC_W-1:0]   ratio;
        logic [ACC_W-1:0]   above;
        int unsigned        span;
        int unsigned        c;
        // Out-of-range column counts act as the nearest legal one
        if (columns_word == '0)
            span = 1;
        else if (columns_word > MAX_COLUMNS)
            span = MAX_COLUMNS;
        else
            span = columns_word;
        // Count shrank under the current position: start a fresh row
        if (col_pos >= span)
        begin
            col_pos = '0;
            top_row = 1'b0;
        end
        c = col_pos;
        // Acceptance in Q1.16: empty bin is zero, no accepted events is one LSB
        if (raw == '0)
            ratio = '0;
        else if (acc == '0)
            ratio = ACC_MIN;
        else
        begin
            quotient = {acc, {QUO_W{1'b0}}} / raw;
            ratio = (quotient > ACC_ONE) ? ACC_ONE : quotient[ACC_W-1:0];
        end
        above = row_above[c];
        if (c > 0)
            add_pair_term(ratio, left_ratio);
        if (!top_row)
        begin
            if (c > 0)
                add_pair_term(ratio, upleft_ratio);
            add_pair_term(ratio, above);
            if (c + 1 < span)
                add_pair_term(ratio, row_above[c + 1]);
        end
        row_above[c] = ratio;
        upleft_ratio = above;
        left_ratio = ratio;
        if (c + 1 >= span)
        begin
            col_pos = '0;
            top_row = 1'b0;
        end
        else
        begin
            col_pos = COL_W'(c + 1);
        end
        // Closing bin: hand over the total and start a fresh map
        if (closes_map)
        begin
            expected_totals.push_back('{total: map_sum, clipped: map_clipped});
            col_pos = '0;
            top_row = 1'b1;
            map_sum = '0;
            map_clipped = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_word = COLS_RESET;
            foreach (row_above[i])
                row_above[i] = '0;
            left_ratio = '0;
            upleft_ratio = '0;
            col_pos = '0;
            top_row = 1'b1;
            map_sum = '0;
            map_clipped = 1'b0;
            expected_totals.delete();
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_IDX_COLS)
                columns_word = pwdata[CFG_W-1:0];
            if (in_valid && in_ready)
                predict_bin(accepted_count, raw_count, last_bin);
            // Compare each result transfer with the oldest queued total
            if (out_valid && out_ready)
            begin
                if (expected_totals.size() == 0)
                begin
                    $error("unexpected map total: roughness %0d, saturated %0b",
                           roughness, saturated);
                    error_count++;
                end
                else
                begin
                    oldest_total = expected_totals.pop_front();
                    if (roughness !== oldest_total.total)
                    begin
                        $error("roughness: expected %0d, actual %0d",
                               oldest_total.total, roughness);
                        error_count++;
                    end
                    if (saturated !== oldest_total.clipped)
                    begin
                        $error("saturated: expected %0b, actual %0b",
                               oldest_total.clipped, saturated);
                        error_count++;
                    end
                    checked_count++;
                end
            end
        end
        pending_totals <= expected_totals.size();
        totals_checked <= checked_count;
        mismatches <= error_count;
    end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import amr_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [CNT_W-1:0]     accepted_count = '0;
    logic [CNT_W-1:0]     raw_count = '0;
    logic                 last_bin = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    logic [SUM_W-1:0]     roughness;
    logic                 saturated;

    int pending_totals;
    int totals_checked;
    int mismatches;
    int bins_sent = 0;
    bit sender_burst = 1'b0;
    bit sink_burst = 1'b0;

    acceptance_map_roughness dut (.*);

    roughness_checker checker_inst (.*);

    always #10 clk = ~clk;

    // Hold off a random number of cycles, then present one bin until its transfer
    task automatic send_bin(input logic [CNT_W-1:0] acc, input logic [CNT_W-1:0] raw,
                            input logic closes_map);
        int unsigned gap;
        gap = sender_burst ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        accepted_count <= acc;
        raw_count <= raw;
        last_bin <= closes_map;
        do @(posedge clk); while (!in_ready);
        bins_sent++;
    endtask

    // Drop valid, wait for every queued total, then let the datapath go quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_totals != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Setup and access cycle on the register port
    task automatic write_columns(input logic [CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_IDX_COLS, 2'b00};
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Result side: stall a random number of cycles after each result shows up
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_burst ? 0 : $urandom_range(0, 17);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                do @(posedge clk); while (!out_valid);
                repeat (stall - 1) @(posedge clk);
                out_ready <= 1'b1;
            end
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        int unsigned      pick;
        int unsigned      span;
        int unsigned      map_count;
        int unsigned      map_len;
        int unsigned      settle;
        int               settings_used;
        int               open_changes;
        logic [CFG_W-1:0] cols_word;
        logic [CNT_W-1:0] acc;
        logic [CNT_W-1:0] raw;
        bit               leave_open;
        bit               wide_phase;
        bit               wide_done;
        bit               closing;

        settings_used = 0;
        open_changes = 0;
        wide_done = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset count of 256: one row, left pairs only, every acceptance corner
        send_bin(16'h0000, 16'h0000, 1'b0);
        send_bin(16'h0000, 16'd100, 1'b0);
        send_bin(16'hFFFF, 16'hFFFF, 1'b0);
        send_bin(16'hFFFF, 16'h0001, 1'b0);
        send_bin(16'h0001, 16'hFFFF, 1'b0);
        send_bin(16'd40000, 16'hFFFF, 1'b0);
        send_bin(16'h0000, 16'h0000, 1'b0);
        send_bin(16'h8000, 16'hFFFF, 1'b1);
        drain_results();

        // Zero count acts as one column: vertical pairs only, then a one-bin map
        write_columns('0);
        send_bin(16'd5, 16'd10, 1'b0);
        send_bin(16'd7, 16'd10, 1'b0);
        send_bin(16'd0, 16'd3, 1'b0);
        send_bin(16'd9, 16'd9, 1'b1);
        send_bin(16'd123, 16'd456, 1'b1);
        drain_results();

        // Three columns: full neighbor set, with a tiny, a clipped and an empty bin
        write_columns(9'd3);
        for (int i = 0; i < 9; i++)
            send_bin(CNT_W'(i * 8000), (i == 7) ? 16'h0000 : 16'hF000, i == 8);
        drain_results();
        settings_used = 3;

        // Random maps over many column settings, one wide run at the largest count
        while (bins_sent < 750)
        begin
            pick = $urandom_range(0, 15);
            wide_phase = !wide_done && bins_sent >= 200;
            if (wide_phase)
                cols_word = '1;
            else if (pick == 0)
                cols_word = '0;
            else if (pick == 1)
                cols_word = 9'd256;
            else if (pick == 2)
                cols_word = CFG_W'($urandom_range(257, 510));
            else if (pick < 5)
                cols_word = CFG_W'($urandom_range(9, 40));
            else
                cols_word = CFG_W'($urandom_range(1, 8));
            span = (cols_word == '0) ? 1 : (cols_word > MAX_COLUMNS) ? MAX_COLUMNS : cols_word;

            write_columns(cols_word);
            settings_used++;
            sender_burst = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            leave_open = !wide_phase && ($urandom_range(0, 3) == 0);
            map_count = wide_phase ? 1 : $urandom_range(1, 4);

            for (int m = 0; m < map_count; m++)
            begin
                if (wide_phase)
                    map_len = MAX_COLUMNS + $urandom_range(2, 8);
                else if (span > 40)
                    map_len = $urandom_range(1, 12);
                else
                    map_len = $urandom_range(1, 4) * span + $urandom_range(0, span - 1);
                for (int b = 0; b < map_len; b++)
                begin
                    case ($urandom_range(0, 9))
                        0:
                        begin
                            acc = CNT_W'($urandom);
                            raw = '0;
                        end
                        1:
                        begin
                            acc = '0;
                            raw = CNT_W'($urandom_range(1, 65535));
                        end
                        2:
                        begin
                            acc = CNT_W'($urandom);
                            raw = CNT_W'($urandom);
                        end
                        3:
                        begin
                            acc = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001;
                            raw = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0001;
                        end
                        default:
                        begin
                            raw = CNT_W'($urandom_range(1, 65535));
                            acc = CNT_W'($urandom_range(0, raw));
                        end
                    endcase
                    // Close on the final bin unless the map is left open; rarely close early
                    closing = (b == map_len - 1) && !(leave_open && m == map_count - 1);
                    send_bin(acc, raw, closing || ($urandom_range(0, 39) == 0));
                end
            end
            if (leave_open)
                open_changes++;
            if (wide_phase)
                wide_done = 1'b1;
            drain_results();
        end

        // Final drain with a bound, then the verdict
        sender_burst = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        settle = 0;
        while (pending_totals != 0 && settle < 5000)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (40) @(posedge clk);
        if (pending_totals != 0)
            $error("%0d map totals never arrived", pending_totals);
        $display("Sent %0d bins under %0d column settings (0 to 511), %0d left a row open",
                 bins_sent, settings_used, open_changes);
        $display("Checked %0d map totals, with gaps and stalls on both channels",
                 totals_checked);
        if (mismatches == 0 && pending_totals == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/amr_pkg.sv
rtl/core/amr_ram.sv
rtl/core/amr_div.sv
rtl/core/amr_acc.sv
rtl/core/acceptance_map_roughness.sv
rtl/core/amr_checker.sv
tb/sv/roughness_checker.sv
tb/sv/tb_top.sv
